>>> src/playfair_digraph_cipher_assert.svh
// Assertion macros for the Playfair digraph cipher.
// No dependencies; included inside the top-level module.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfc assertion failed");

// Next-cycle implication, disabled during reset.
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfc assertion failed");

`endif

>>> src/pfc_pkg.sv
// Shared types and constants for the Playfair digraph cipher.
// No dependencies.
package pfc_pkg;

    localparam int unsigned SQ_DIM   = 5;
    localparam int unsigned SQ_CELLS = SQ_DIM * SQ_DIM;

    localparam logic [4:0] CODE_I = 5'd8;
    localparam logic [4:0] CODE_J = 5'd9;

    typedef logic [4:0] t_code;
    typedef logic [2:0] t_rc;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SQ_ROWS01 = 2'd0,
        CFG_SQ_ROWS23 = 2'd1,
        CFG_SQ_ROW4   = 2'd2,
        CFG_DECRYPT   = 2'd3
    } t_cfg_idx;

    // Row and column of each cell, row-major
    localparam t_rc ROW_OF [SQ_CELLS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };
    localparam t_rc COL_OF [SQ_CELLS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4
    };

    typedef struct packed {
        t_code first_letter;
        t_code second_letter;
        logic  last_pair;
    } t_pf_in;

    typedef struct packed {
        t_code first_out;
        t_code second_out;
        logic  last_out;
        logic  square_miss;
    } t_pf_out;

    // One step around a row or column of five, forward or back
    function automatic t_rc step_wrap(t_rc v, logic back);
        t_rc r;
        if (back) begin
            r = (v == 3'd0) ? 3'(SQ_DIM - 1) : v - 3'd1;
        end else begin
            r = (v == 3'(SQ_DIM - 1)) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

>>> src/playfair_digraph_cipher.sv
// Playfair digraph cipher over a configurable 5x5 key square, top level.
// Depends on pfc_pkg and playfair_digraph_cipher_assert.svh.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | pfc_pkg::t_pf_in (one digraph)
//  out     | from block| o_out_valid / i_out_stall  | pfc_pkg::t_pf_out (one result)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Four-stage pipeline (compare, encode, digraph rules, cell read), one digraph per
// cycle while i_out_stall lets results drain.
// i_rst_n (sync, active low) clears stage valids and the config registers (square = 0).
// Each stage holds only while the stage after it is full and holding, so bubbles
// are squeezed out; o_in_stall rises only with a held result and a full pipe.
module playfair_digraph_cipher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pfc_pkg::t_pf_in       i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pfc_pkg::t_pf_out      o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [49:0]           i_cfg_data
);

    localparam int unsigned NC = pfc_pkg::SQ_CELLS;

    // ---------------- configuration ----------------
    logic [49:0] r_sq01;
    logic [49:0] r_sq23;
    logic [24:0] r_sq4;
    logic        r_decrypt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq01    <= '0;
            r_sq23    <= '0;
            r_sq4     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfc_pkg::CFG_SQ_ROWS01: r_sq01    <= i_cfg_data;
                pfc_pkg::CFG_SQ_ROWS23: r_sq23    <= i_cfg_data;
                pfc_pkg::CFG_SQ_ROW4:   r_sq4     <= i_cfg_data[24:0];
                pfc_pkg::CFG_DECRYPT:   r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Unpacked view of the square, row-major
    pfc_pkg::t_code sq_cell [NC];
    always_comb begin
        for (int k = 0; k < 10; k++) begin
            sq_cell[k]      = r_sq01[5*k +: 5];
            sq_cell[10 + k] = r_sq23[5*k +: 5];
        end
        for (int k = 0; k < 5; k++) begin
            sq_cell[20 + k] = r_sq4[5*k +: 5];
        end
    end

    // ---------------- flow control ----------------
    // Each stage loads when it is empty or its contents move on.
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic en1, en2, en3, en4;

    assign en4 = !r_out_valid || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) r_v1        <= i_in_valid;
            if (en2) r_v2        <= r_v1;
            if (en3) r_v3        <= r_v2;
            if (en4) r_out_valid <= r_v3;
        end
    end

    // ---------------- stage 1: fold J into I, compare against all cells ----------------
    pfc_pkg::t_code key_a, key_b;
    logic [NC-1:0]  n_hit_a, n_hit_b;
    logic [NC-1:0]  r_hit_a, r_hit_b;
    logic           r_last1;

    always_comb begin
        key_a = (i_in_data.first_letter  == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I
                                                             : i_in_data.first_letter;
        key_b = (i_in_data.second_letter == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I
                                                             : i_in_data.second_letter;
        for (int k = 0; k < NC; k++) begin
            n_hit_a[k] = (sq_cell[k] == key_a);
            n_hit_b[k] = (sq_cell[k] == key_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hit_a <= n_hit_a;
            r_hit_b <= n_hit_b;
            r_last1 <= i_in_data.last_pair;
        end
    end

    // ---------------- stage 2: keep the last hit in row-major order, encode it ----------------
    // A cell is the last hit when it hits and no later cell does.
    pfc_pkg::t_rc n_ra, n_ca, n_rb, n_cb;
    pfc_pkg::t_rc r_ra, r_ca, r_rb, r_cb;
    logic         r_found_a, r_found_b, r_last2;

    always_comb begin
        n_ra = '0;
        n_ca = '0;
        n_rb = '0;
        n_cb = '0;
        for (int k = 0; k < NC; k++) begin
            if (r_hit_a[k] && ((r_hit_a >> (k + 1)) == '0)) begin
                n_ra = n_ra | pfc_pkg::ROW_OF[k];
                n_ca = n_ca | pfc_pkg::COL_OF[k];
            end
            if (r_hit_b[k] && ((r_hit_b >> (k + 1)) == '0)) begin
                n_rb = n_rb | pfc_pkg::ROW_OF[k];
                n_cb = n_cb | pfc_pkg::COL_OF[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ra      <= n_ra;
            r_ca      <= n_ca;
            r_rb      <= n_rb;
            r_cb      <= n_cb;
            r_found_a <= |r_hit_a;
            r_found_b <= |r_hit_b;
            r_last2   <= r_last1;
        end
    end

    // ---------------- stage 3: digraph rules ----------------
    // Same row wins over same column; equal letters land in same row.
    pfc_pkg::t_rc n_ora, n_oca, n_orb, n_ocb;
    pfc_pkg::t_rc r_ora, r_oca, r_orb, r_ocb;
    logic         r_miss3, r_last3;

    always_comb begin
        if (r_ra == r_rb) begin
            n_ora = r_ra;
            n_orb = r_rb;
            n_oca = pfc_pkg::step_wrap(r_ca, r_decrypt);
            n_ocb = pfc_pkg::step_wrap(r_cb, r_decrypt);
        end else if (r_ca == r_cb) begin
            n_ora = pfc_pkg::step_wrap(r_ra, r_decrypt);
            n_orb = pfc_pkg::step_wrap(r_rb, r_decrypt);
            n_oca = r_ca;
            n_ocb = r_cb;
        end else begin
            // rectangle: swap columns
            n_ora = r_ra;
            n_orb = r_rb;
            n_oca = r_cb;
            n_ocb = r_ca;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ora   <= n_ora;
            r_oca   <= n_oca;
            r_orb   <= n_orb;
            r_ocb   <= n_ocb;
            r_miss3 <= !(r_found_a && r_found_b);
            r_last3 <= r_last2;
        end
    end

    // ---------------- stage 4: read the chosen cells into the output register ----------------
    pfc_pkg::t_code n_out_a, n_out_b;
    pfc_pkg::t_pf_out r_out;

    always_comb begin
        n_out_a = '0;
        n_out_b = '0;
        for (int k = 0; k < NC; k++) begin
            if (pfc_pkg::ROW_OF[k] == r_ora && pfc_pkg::COL_OF[k] == r_oca) begin
                n_out_a = n_out_a | sq_cell[k];
            end
            if (pfc_pkg::ROW_OF[k] == r_orb && pfc_pkg::COL_OF[k] == r_ocb) begin
                n_out_b = n_out_b | sq_cell[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out.first_out   <= r_miss3 ? '0 : n_out_a;
            r_out.second_out  <= r_miss3 ? '0 : n_out_b;
            r_out.last_out    <= r_last3;
            r_out.square_miss <= r_miss3;
        end
    end

    assign o_out_data = r_out;

    // ---------------- assertions ----------------
`include "playfair_digraph_cipher_assert.svh"

    // A miss never carries letters
    `PFC_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && o_out_data.square_miss, o_out_data.first_out == '0 && o_out_data.second_out == '0)

    // Input backs up only behind a held result
    `PFC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // With the output draining, an accepted beat shows up on o_out_valid once it has passed every pipeline stage
    `PFC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall && !i_out_stall) ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, o_out_valid)

endmodule
